>>> rtl/core/cmct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmct_pkg
// Shared types and constants of the color marker corner tracker.
// ----------------------------------------------------------------------------
package cmct_pkg;

   // Configuration register layout
   localparam int CSR_DATA_BITS   = 41;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int ENABLE_BIT      = 40;
   localparam int RGB_MSB         = 39;
   localparam int RGB_LSB         = 16;
   localparam int BOUND_BITS      = 16;

   // Payload widths
   localparam int RGB_BITS        = 24;
   localparam int PIXEL_BITS      = 32;
   localparam int GRID_COORD_BITS = 10;
   localparam int BIND_INDEX_BITS = 2;

   // Corner slots inside a tracker
   localparam int NUM_CORNERS     = 4;
   localparam int CORNER_UL       = 0;
   localparam int CORNER_UR       = 1;
   localparam int CORNER_DR       = 2;
   localparam int CORNER_DL       = 3;

   typedef enum logic {
      CMD_EXAMINE = 1'b0,
      CMD_REPORT  = 1'b1
   } command_type;

   typedef struct packed {
      command_type                command;
      logic [GRID_COORD_BITS-1:0] cell_row;
      logic [GRID_COORD_BITS-1:0] cell_col;
      logic [PIXEL_BITS-1:0]      pixel_rgba;
   } req_payload_type;

   typedef struct packed {
      logic [BIND_INDEX_BITS-1:0] bind_index;
      logic                       found;
      logic [GRID_COORD_BITS-1:0] ul_row;
      logic [GRID_COORD_BITS-1:0] ul_col;
      logic [GRID_COORD_BITS-1:0] ur_row;
      logic [GRID_COORD_BITS-1:0] ur_col;
      logic [GRID_COORD_BITS-1:0] dr_row;
      logic [GRID_COORD_BITS-1:0] dr_col;
      logic [GRID_COORD_BITS-1:0] dl_row;
      logic [GRID_COORD_BITS-1:0] dl_col;
      logic [BOUND_BITS-1:0]      bound_value;
      logic                       last_report;
   } rsp_payload_type;

   // Broadcast from the top level to every cell
   typedef struct packed {
      logic                examine;
      logic                report;
      logic [RGB_BITS-1:0] rgb;
   } cell_ctrl_type;

   // Report record travelling down the cell chain
   typedef struct packed {
      logic            valid;
      rsp_payload_type rec;
   } slot_type;

endpackage

>>> rtl/core/cmct_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmct_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface cmct_stream_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

>>> rtl/core/cmct_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmct_cell
// One bind: its register, its corner tracker and one slot of the report chain.
// ----------------------------------------------------------------------------
module cmct_cell
   import cmct_pkg::*;
#(
   parameter int INDEX      = 0
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write,
   input  logic [CSR_DATA_BITS-1:0]   csr_data,
   input  cell_ctrl_type              ctrl,
   input  logic [GRID_COORD_BITS-1:0] cell_row,
   input  logic [GRID_COORD_BITS-1:0] cell_col,
   input  logic                       en_above_i,
   output logic                       en_above_o,
   input  slot_type                   up_slot,
   output logic                       up_take,
   output slot_type                   down_slot,
   input  logic                       down_take
);

   logic [CSR_DATA_BITS-1:0]   bind_ff, bind_in;
   logic                       seen_ff, seen_in;
   logic [GRID_COORD_BITS-1:0] row_ff [NUM_CORNERS];
   logic [GRID_COORD_BITS-1:0] col_ff [NUM_CORNERS];
   logic [NUM_CORNERS-1:0]     move;
   slot_type                   slot_ff, slot_in;
   logic                       enabled;
   logic                       match;
   logic                       room;
   rsp_payload_type            snap;

   assign enabled    = bind_ff[ENABLE_BIT];
   assign match      = ctrl.examine && enabled && (bind_ff[RGB_MSB:RGB_LSB] == ctrl.rgb);
   assign en_above_o = en_above_i | enabled;

   // Dominance test, one per corner; first match takes all four
   always_comb begin
      for (int c = 0; c < NUM_CORNERS; c++) begin
         logic row_ok;
         logic col_ok;
         row_ok = (c == CORNER_UL || c == CORNER_UR) ? (cell_row <= row_ff[c])
                                                     : (cell_row >= row_ff[c]);
         col_ok = (c == CORNER_UL || c == CORNER_DL) ? (cell_col <= col_ff[c])
                                                     : (cell_col >= col_ff[c]);
         move[c] = match && (!seen_ff || (row_ok && col_ok));
      end
   end

   // Register and seen flag
   always_comb begin
      bind_in = csr_write ? csr_data : bind_ff;
      if (ctrl.report) begin
         seen_in = 1'b0;
      end else if (match) begin
         seen_in = 1'b1;
      end else begin
         seen_in = seen_ff;
      end
   end

   // Snapshot of this bind for a report
   always_comb begin
      snap             = '0;
      snap.bind_index  = BIND_INDEX_BITS'(INDEX);
      snap.found       = seen_ff;
      if (seen_ff) begin
         snap.ul_row = row_ff[CORNER_UL];
         snap.ul_col = col_ff[CORNER_UL];
         snap.ur_row = row_ff[CORNER_UR];
         snap.ur_col = col_ff[CORNER_UR];
         snap.dr_row = row_ff[CORNER_DR];
         snap.dr_col = col_ff[CORNER_DR];
         snap.dl_row = row_ff[CORNER_DL];
         snap.dl_col = col_ff[CORNER_DL];
      end
      snap.bound_value = bind_ff[BOUND_BITS-1:0];
      snap.last_report = !en_above_i;
   end

   // Report slot: load on a report, otherwise shift toward the output
   assign room      = !slot_ff.valid || down_take;
   assign up_take   = room;
   assign down_slot = slot_ff;

   always_comb begin
      slot_in = slot_ff;
      if (ctrl.report) begin
         slot_in.valid = enabled;
         slot_in.rec   = snap;
      end else if (room) begin
         slot_in = up_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bind_ff       <= '0;
         seen_ff       <= 1'b0;
         slot_ff.valid <= 1'b0;
      end else begin
         bind_ff <= bind_in;
         seen_ff <= seen_in;
         slot_ff <= slot_in;
      end
   end

   // Corner coordinates, meaningful only while seen
   always_ff @(posedge clock) begin
      for (int c = 0; c < NUM_CORNERS; c++) begin
         if (move[c]) begin
            row_ff[c] <= cell_row;
            col_ff[c] <= cell_col;
         end
      end
   end

endmodule

>>> rtl/core/color_marker_corner_tracker_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_marker_corner_tracker_unit
// Tracks four corners per color bind over a raster of cells, reports quads.
// ----------------------------------------------------------------------------
//  channel  | dir | payload            | notes
//  ---------+-----+--------------------+-----------------------------------
//  req_chan | in  | req_payload_type   | examine cell or report command
//  rsp_chan | out | rsp_payload_type   | one quad per enabled bind
//  csr_*    | in  | index, 41-bit data | bind registers, write only
//
//  An examine transaction is taken every cycle and updates all cells at once.
//  A report loads one record per enabled bind into the cell chain; records
//  move one cell a cycle toward the output register while there is room,
//  so a following report waits until rsp_chan has drained the chain.
//  Synchronous reset clears the registers, seen flags and report chain.
//  A stalled rsp_chan only blocks the next report, not tracking.
// ----------------------------------------------------------------------------
module color_marker_corner_tracker_unit
   import cmct_pkg::*;
#(
   parameter int NUM_BINDS  = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   cmct_stream_if.sink               req_chan,
   cmct_stream_if.source             rsp_chan,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   slot_type             slot_chain [NUM_BINDS+1];
   logic [NUM_BINDS:0]   take_chain;
   logic [NUM_BINDS:0]   en_chain;
   logic [NUM_BINDS-1:0] slot_valid;
   logic [NUM_BINDS-1:0] slot_last;
   logic                 any_slot;
   logic                 req_xfer;
   cell_ctrl_type        ctrl;
   logic [GRID_COORD_BITS-1:0] row_cut;
   logic [GRID_COORD_BITS-1:0] col_cut;
   logic                 out_take;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_payload_type      rsp_data_ff, rsp_data_in;

   // Input side: reports wait for an empty chain, examines always pass
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !any_slot || (req_chan.payload.command == CMD_EXAMINE);
   assign ctrl.examine   = req_xfer && (req_chan.payload.command == CMD_EXAMINE);
   assign ctrl.report    = req_xfer && (req_chan.payload.command == CMD_REPORT);
   assign ctrl.rgb       = req_chan.payload.pixel_rgba[PIXEL_BITS-1:PIXEL_BITS-RGB_BITS];
   assign row_cut        = req_chan.payload.cell_row;
   assign col_cut        = req_chan.payload.cell_col;

   // Chain ends
   assign slot_chain[NUM_BINDS] = '0;
   assign en_chain[NUM_BINDS]   = 1'b0;
   assign take_chain[0]         = out_take;

   for (genvar i = 0; i < NUM_BINDS; i++) begin : g_cell
      logic sel;
      assign sel           = csr_write && (csr_index == CSR_INDEX_BITS'(i));
      assign slot_valid[i] = slot_chain[i].valid;
      assign slot_last[i]  = slot_chain[i].rec.last_report;

      cmct_cell #(
         .INDEX      (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .csr_write  (sel),
         .csr_data   (csr_data),
         .ctrl       (ctrl),
         .cell_row   (row_cut),
         .cell_col   (col_cut),
         .en_above_i (en_chain[i+1]),
         .en_above_o (en_chain[i]),
         .up_slot    (slot_chain[i+1]),
         .up_take    (take_chain[i+1]),
         .down_slot  (slot_chain[i]),
         .down_take  (take_chain[i])
      );
   end

   assign any_slot = |slot_valid;

   // Output register
   assign out_take = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_take) begin
         rsp_valid_in = slot_chain[0].valid;
         if (slot_chain[0].valid) begin
            rsp_data_in = slot_chain[0].rec;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

`ifndef ASSERT_OFF
   // A report with no enabled bind leaves the chain empty
   a_empty_report: assert property (@(posedge clock) disable iff (reset)
      (ctrl.report && !en_chain[0]) |=> !any_slot)
      else $error("report without enabled bind filled the chain");

   // At most one pending record is marked last
   a_one_last: assert property (@(posedge clock) disable iff (reset)
      $countones(slot_valid & slot_last) <= 1)
      else $error("more than one last record in the chain");

   // A report loads the chain only from empty
   a_load_empty: assert property (@(posedge clock) disable iff (reset)
      ctrl.report |-> !any_slot)
      else $error("report accepted while records pending");
`endif

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for color_marker_corner_tracker_unit. A queue of cell
// and report transactions feeds a valid/ready driver. A monitor keeps its own
// copy of the bind registers and corner trackers, predicts the quads of each
// report and compares every quad field by field. Both channels idle at random
// in the first two of three phases, with bind registers rewritten while the unit is idle.
// ----------------------------------------------------------------------------
module tb
   import cmct_pkg::*;
();

   localparam int NUM_BINDS      = 4;
   localparam int SETTLE_CYCLES  = 12;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int ITEMS_PER_RUN  = 430;
   localparam int NUM_PHASES     = 3;

   logic clock;
   logic reset;
   logic                      csr_write;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_data;

   cmct_stream_if #(.payload_type(req_payload_type)) req_if ();
   cmct_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   color_marker_corner_tracker_unit #(
      .NUM_BINDS  (NUM_BINDS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Stimulus and prediction state
   req_payload_type            queued_cells [$];
   rsp_payload_type            pending_quads [$];
   logic [CSR_DATA_BITS-1:0]   bind_regs [NUM_BINDS];
   logic [CSR_DATA_BITS-1:0]   next_regs [NUM_BINDS];
   bit                         bind_seen [NUM_BINDS];
   logic [GRID_COORD_BITS-1:0] corner_row [NUM_BINDS][NUM_CORNERS];
   logic [GRID_COORD_BITS-1:0] corner_col [NUM_BINDS][NUM_CORNERS];
   int                         send_idle_pct;
   int                         recv_stall_pct;
   int                         fail_count = 0;
   int unsigned                cycle_count = 0;

   // Clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Update the tracker copy with one accepted transaction; queue report quads
   function automatic void apply_cell_transaction(req_payload_type t);
      rsp_payload_type            q;
      logic [RGB_BITS-1:0]        rgb;
      logic [GRID_COORD_BITS-1:0] r;
      logic [GRID_COORD_BITS-1:0] k;
      bit                         row_ok;
      bit                         col_ok;
      int                         last_b;
      r = t.cell_row;
      k = t.cell_col;
      if (t.command == CMD_EXAMINE) begin
         rgb = t.pixel_rgba[PIXEL_BITS-1:8];
         for (int b = 0; b < NUM_BINDS; b++) begin
            if (!bind_regs[b][ENABLE_BIT] || bind_regs[b][RGB_MSB:RGB_LSB] != rgb)
               continue;
            if (!bind_seen[b]) begin
               // first match pins all four corners
               bind_seen[b] = 1'b1;
               for (int c = 0; c < NUM_CORNERS; c++) begin
                  corner_row[b][c] = r;
                  corner_col[b][c] = k;
               end
            end else begin
               for (int c = 0; c < NUM_CORNERS; c++) begin
                  row_ok = (c == CORNER_UL || c == CORNER_UR) ?
                           (r <= corner_row[b][c]) : (r >= corner_row[b][c]);
                  col_ok = (c == CORNER_UL || c == CORNER_DL) ?
                           (k <= corner_col[b][c]) : (k >= corner_col[b][c]);
                  if (row_ok && col_ok) begin
                     corner_row[b][c] = r;
                     corner_col[b][c] = k;
                  end
               end
            end
         end
      end else begin
         last_b = -1;
         for (int b = 0; b < NUM_BINDS; b++)
            if (bind_regs[b][ENABLE_BIT]) last_b = b;
         for (int b = 0; b < NUM_BINDS; b++) begin
            if (!bind_regs[b][ENABLE_BIT]) continue;
            // unseen trackers hold zero corners
            q.bind_index  = BIND_INDEX_BITS'(b);
            q.found       = bind_seen[b];
            q.ul_row      = corner_row[b][CORNER_UL];
            q.ul_col      = corner_col[b][CORNER_UL];
            q.ur_row      = corner_row[b][CORNER_UR];
            q.ur_col      = corner_col[b][CORNER_UR];
            q.dr_row      = corner_row[b][CORNER_DR];
            q.dr_col      = corner_col[b][CORNER_DR];
            q.dl_row      = corner_row[b][CORNER_DL];
            q.dl_col      = corner_col[b][CORNER_DL];
            q.bound_value = bind_regs[b][BOUND_BITS-1:0];
            q.last_report = (b == last_b);
            pending_quads = {pending_quads, q};
         end
         // every tracker clears, enabled or not
         for (int b = 0; b < NUM_BINDS; b++) begin
            bind_seen[b] = 1'b0;
            for (int c = 0; c < NUM_CORNERS; c++) begin
               corner_row[b][c] = '0;
               corner_col[b][c] = '0;
            end
         end
      end
   endfunction

   function automatic void check_quad_field(string name, logic [31:0] expv, logic [31:0] actv);
      if (expv !== actv) begin
         $error("%s mismatch: expected %0h, got %0h", name, expv, actv);
         fail_count++;
      end
   endfunction

   // Driver: next queued transaction once the current one is taken
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (queued_cells.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_if.valid   <= 1'b1;
            req_if.payload <= queued_cells.pop_front();
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Receiver back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Monitor: check quads, then predict from accepted requests
   always @(posedge clock) begin
      rsp_payload_type want;
      rsp_payload_type got;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.payload;
            if (pending_quads.size() == 0) begin
               $error("quad for bind %0d with no report outstanding", got.bind_index);
               fail_count++;
            end else begin
               want = pending_quads.pop_front();
               check_quad_field("bind_index", 32'(want.bind_index), 32'(got.bind_index));
               check_quad_field("found", 32'(want.found), 32'(got.found));
               check_quad_field("ul_row", 32'(want.ul_row), 32'(got.ul_row));
               check_quad_field("ul_col", 32'(want.ul_col), 32'(got.ul_col));
               check_quad_field("ur_row", 32'(want.ur_row), 32'(got.ur_row));
               check_quad_field("ur_col", 32'(want.ur_col), 32'(got.ur_col));
               check_quad_field("dr_row", 32'(want.dr_row), 32'(got.dr_row));
               check_quad_field("dr_col", 32'(want.dr_col), 32'(got.dr_col));
               check_quad_field("dl_row", 32'(want.dl_row), 32'(got.dl_row));
               check_quad_field("dl_col", 32'(want.dl_col), 32'(got.dl_col));
               check_quad_field("bound_value", 32'(want.bound_value),
                                32'(got.bound_value));
               check_quad_field("last_report", 32'(want.last_report),
                                32'(got.last_report));
            end
         end
         if (req_if.valid && req_if.ready)
            apply_cell_transaction(req_if.payload);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic void queue_cell(logic [9:0] r, logic [9:0] k, logic [31:0] rgba);
      req_payload_type t;
      t.command    = CMD_EXAMINE;
      t.cell_row   = r;
      t.cell_col   = k;
      t.pixel_rgba = rgba;
      queued_cells = {queued_cells, t};
   endfunction

   // Report with junk cell fields, which the unit ignores
   function automatic void queue_report();
      req_payload_type t;
      t.command    = CMD_REPORT;
      t.cell_row   = GRID_COORD_BITS'($urandom);
      t.cell_col   = GRID_COORD_BITS'($urandom);
      t.pixel_rgba = $urandom;
      queued_cells = {queued_cells, t};
   endfunction

   // Coordinate per frame style: full range, tight cluster, or grid edges
   function automatic logic [9:0] pick_coord(int mode, logic [9:0] base);
      case (mode)
         0: pick_coord = GRID_COORD_BITS'($urandom_range(1023));
         1: pick_coord = base + GRID_COORD_BITS'($urandom_range(3));
         default: pick_coord = $urandom_range(1) ? 10'h3ff : 10'h000;
      endcase
   endfunction

   task automatic wait_idle();
      do @(negedge clock);
      while (queued_cells.size() != 0 || req_if.valid || pending_quads.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Write all bind registers from next_regs; unit must be idle
   task automatic program_binds();
      for (int i = 0; i < NUM_BINDS; i++) begin
         @(posedge clock);
         csr_write    <= 1'b1;
         csr_index    <= CSR_INDEX_BITS'(i);
         csr_data     <= next_regs[i];
         bind_regs[i] = next_regs[i];
      end
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // Stimulus
   initial begin
      int                  phase_items;
      int                  frame_len;
      int                  mode;
      int                  sel;
      logic [9:0]          base_r;
      logic [9:0]          base_c;
      logic [RGB_BITS-1:0] rgb;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;
      csr_write      = 1'b0;
      csr_index      = '0;
      csr_data       = '0;
      reset          = 1'b1;
      send_idle_pct  = 15;
      recv_stall_pct = 72;
      for (int b = 0; b < NUM_BINDS; b++) begin
         bind_regs[b] = '0;
         bind_seen[b] = 1'b0;
         for (int c = 0; c < NUM_CORNERS; c++) begin
            corner_row[b][c] = '0;
            corner_col[b][c] = '0;
         end
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: report with every bind disabled yields nothing
      @(negedge clock);
      queue_report();
      wait_idle();

      // Two binds share a color, one white bind, one disabled bind
      next_regs[0] = {1'b1, 24'hc0ffee, 16'hffff};
      next_regs[1] = {1'b1, 24'hc0ffee, 16'h0000};
      next_regs[2] = {1'b1, 24'hffffff, 16'h1234};
      next_regs[3] = {1'b0, 24'h000000, 16'ha5a5};
      program_binds();
      @(negedge clock);
      queue_cell(10'd512, 10'd512, 32'hc0ffee00);
      queue_cell(10'd0,   10'd0,   32'hc0ffeeff);
      queue_cell(10'd1023, 10'd1023, 32'hc0ffee5a);
      queue_cell(10'd0,   10'd1023, 32'hc0ffee01);
      queue_cell(10'd1023, 10'd0,   32'hc0ffee80);
      queue_cell(10'd512, 10'd512, 32'hc0ffee00);
      queue_cell(10'd3,   10'd3,   32'hffffff7f);
      queue_cell(10'd5,   10'd5,   32'h000000ff);
      queue_cell(10'd7,   10'd9,   32'h12345678);
      queue_report();
      queue_report();
      queue_cell(10'd100, 10'd200, 32'hc0ffee33);
      wait_idle();

      // Rewrite between cells: trackers survive, bind 1 goes quiet
      next_regs[0] = {1'b1, 24'hc0ffee, 16'h8001};
      next_regs[1] = {1'b0, 24'hc0ffee, 16'h0000};
      next_regs[3] = {1'b1, 24'h000000, 16'hffff};
      program_binds();
      @(negedge clock);
      queue_cell(10'd50, 10'd300, 32'hc0ffee00);
      queue_cell(10'd0,  10'd0,   32'h000000c3);
      queue_report();
      queue_cell(10'd9,  10'd9,   32'hc0ffee00);
      wait_idle();

      // All disabled: report clears silently, then bind 0 shows not found
      for (int b = 0; b < NUM_BINDS; b++) next_regs[b] = '0;
      program_binds();
      @(negedge clock);
      queue_report();
      wait_idle();
      next_regs[0] = {1'b1, 24'hc0ffee, 16'h0001};
      program_binds();
      @(negedge clock);
      queue_report();

      // Random frames over three phases, the last one without idling
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         wait_idle();
         send_idle_pct  = (ph == 0) ? 15 : (ph == 1) ? 72 : 0;
         recv_stall_pct = (ph == 0) ? 72 : (ph == 1) ? 15 : 0;
         phase_items = 0;
         while (phase_items < ITEMS_PER_RUN / NUM_PHASES) begin
            if (phase_items == 0 || $urandom_range(2) == 0) begin
               wait_idle();
               for (int b = 0; b < NUM_BINDS; b++) begin
                  case ($urandom_range(5))
                     0: next_regs[b] = '0;
                     1: next_regs[b] = '1;
                     default: begin
                        if ($urandom_range(3) == 0)
                           rgb = $urandom_range(1) ? 24'hffffff : 24'h000000;
                        else if (b > 0 && $urandom_range(2) == 0)
                           rgb = next_regs[b-1][RGB_MSB:RGB_LSB];
                        else
                           rgb = RGB_BITS'($urandom);
                        next_regs[b] = {1'($urandom_range(3) != 0), rgb,
                                        BOUND_BITS'($urandom)};
                     end
                  endcase
               end
               program_binds();
            end
            @(negedge clock);
            frame_len = $urandom_range(24);
            mode      = $urandom_range(2);
            base_r    = GRID_COORD_BITS'($urandom_range(1020));
            base_c    = GRID_COORD_BITS'($urandom_range(1020));
            for (int i = 0; i < frame_len; i++) begin
               // mostly bind colors with random alpha, some noise, stray reports
               sel = $urandom_range(9);
               rgb = (sel < 8) ? bind_regs[sel % NUM_BINDS][RGB_MSB:RGB_LSB] :
                                 RGB_BITS'($urandom);
               if ($urandom_range(29) == 0)
                  queue_report();
               else
                  queue_cell(pick_coord(mode, base_r), pick_coord(mode, base_c),
                             {rgb, 8'($urandom)});
            end
            if ($urandom_range(4) != 0) queue_report();
            phase_items += frame_len + 1;
         end
      end

      wait_idle();
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
